/* sv/pbs_pkg.sv */
// shared constants for the polygon binomial smoother
`default_nettype none

package pbs_pkg;

    localparam int MAX_PASSES_DEF = 8;
    localparam int COORD_BITS_DEF = 14;

    // passes register
    localparam int PASSES_BITS  = 4;
    localparam int PASSES_RESET = 1;

endpackage

`default_nettype wire

/* sv/polygon_binomial_smoother.sv */
// with no stalls, a vertex leaves the row after the vertex that releases it is accepted;
//   the polygon's final vertex leaves each active pass on its own
// throughput: one vertex per cycle in and out unless the output stalls, set by the row of pass cells, one per pass
// ready runs back combinationally through the cell row
// reset: passes = 1, every cell empty, no output pending; a passes write empties all cells
`default_nettype none

module polygon_binomial_smoother #(
    parameter int MAX_PASSES = pbs_pkg::MAX_PASSES_DEF,
    parameter int COORD_BITS = pbs_pkg::COORD_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire [pbs_pkg::PASSES_BITS-1:0]       i_cfg_passes,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire signed [COORD_BITS-1:0]          i_x_coord,
    input  wire signed [COORD_BITS-1:0]          i_y_coord,
    input  wire                                  i_last_vertex,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic signed [COORD_BITS-1:0]         o_smooth_x,
    output logic signed [COORD_BITS-1:0]         o_smooth_y,
    output logic                                 o_end_of_polygon
);

    logic [MAX_PASSES-1:0] r_cell_en, n_cell_en;
    logic [MAX_PASSES-1:0] reset_en;
    logic                  cfg_acc;

    logic [MAX_PASSES:0]          chain_valid;
    logic [MAX_PASSES:0]          chain_ready;
    logic [MAX_PASSES:0]          chain_last;
    logic signed [COORD_BITS-1:0] chain_x [MAX_PASSES+1];
    logic signed [COORD_BITS-1:0] chain_y [MAX_PASSES+1];

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    // passes above MAX_PASSES simply enable every cell
    always_comb begin
        n_cell_en = r_cell_en;
        for (int s = 0; s < MAX_PASSES; s++) begin
            reset_en[s] = (s < pbs_pkg::PASSES_RESET);
            if (cfg_acc) begin
                n_cell_en[s] = (s < int'(i_cfg_passes));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_en <= reset_en;
        end else begin
            r_cell_en <= n_cell_en;
        end
    end

    assign chain_valid[0] = i_in_valid;
    assign o_in_ready     = chain_ready[0];
    assign chain_x[0]     = i_x_coord;
    assign chain_y[0]     = i_y_coord;
    assign chain_last[0]  = i_last_vertex;

    for (genvar s = 0; s < MAX_PASSES; s++) begin : g_cell
        pbs_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_clear     (cfg_acc),
            .i_enable    (r_cell_en[s]),
            .i_in_valid  (chain_valid[s]),
            .o_in_ready  (chain_ready[s]),
            .i_x         (chain_x[s]),
            .i_y         (chain_y[s]),
            .i_last      (chain_last[s]),
            .o_out_valid (chain_valid[s+1]),
            .i_out_ready (chain_ready[s+1]),
            .o_x         (chain_x[s+1]),
            .o_y         (chain_y[s+1]),
            .o_last      (chain_last[s+1])
        );
    end

    assign chain_ready[MAX_PASSES] = i_out_ready;
    assign o_out_valid             = chain_valid[MAX_PASSES];
    assign o_smooth_x              = chain_x[MAX_PASSES];
    assign o_smooth_y              = chain_y[MAX_PASSES];
    assign o_end_of_polygon        = chain_last[MAX_PASSES];

    // a passes write flushes the output register
    a_cfg_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_acc |=> !o_out_valid)
        else $error("output still valid after passes write");

    // active cells always form a prefix of the row
    a_en_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_cell_en >> 1) & ~r_cell_en) == '0)
        else $error("cell enables not a prefix");

    // zero passes turns every cell into a plain register
    a_zero_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_acc && i_cfg_passes == '0) |=> r_cell_en == '0)
        else $error("cells still active after zero passes write");

endmodule

`default_nettype wire

/* sv/pbs_cell.sv */
// one smoothing pass cell: holds two vertices and a registered output vertex
`default_nettype none

module pbs_cell #(
    parameter int COORD_BITS = pbs_pkg::COORD_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_clear,
    input  wire                          i_enable,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire signed [COORD_BITS-1:0]  i_x,
    input  wire signed [COORD_BITS-1:0]  i_y,
    input  wire                          i_last,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    output logic                         o_last
);

    localparam int SUM_BITS   = COORD_BITS + 2;
    localparam int ROUND_BIAS = 3;

    // fill codes
    localparam logic [1:0] FILL_EMPTY = 2'd0;
    localparam logic [1:0] FILL_FIRST = 2'd1;
    localparam logic [1:0] FILL_INNER = 2'd2;
    localparam logic [1:0] FILL_LAST  = 2'd3;

    logic [1:0]                  r_fill, n_fill;
    logic signed [COORD_BITS-1:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic signed [COORD_BITS-1:0] r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_out_x, r_out_y;
    logic                         r_out_last;

    logic                         load_ok;
    logic                         in_acc;
    logic                         emit;
    logic signed [COORD_BITS-1:0] emit_x, emit_y;
    logic                         emit_last;

    // (a + 2b + c) / 4, truncated toward zero
    function automatic logic signed [COORD_BITS-1:0] smooth3(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b,
        input logic signed [COORD_BITS-1:0] c
    );
        logic signed [SUM_BITS-1:0] sum;
        logic signed [SUM_BITS-1:0] adj;
        sum = SUM_BITS'(a) + (SUM_BITS'(b) <<< 1) + SUM_BITS'(c);
        adj = sum + (sum[SUM_BITS-1] ? SUM_BITS'(ROUND_BIAS) : SUM_BITS'(0));
        return COORD_BITS'(adj >>> 2);
    endfunction

    assign load_ok    = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_fill     = r_fill;
        n_prev_x   = r_prev_x;
        n_prev_y   = r_prev_y;
        n_cur_x    = r_cur_x;
        n_cur_y    = r_cur_y;
        emit       = 1'b0;
        emit_x     = r_cur_x;
        emit_y     = r_cur_y;
        emit_last  = 1'b0;
        o_in_ready = load_ok;
        if (!i_enable) begin
            // inactive pass: plain pipeline register
            n_fill    = FILL_EMPTY;
            emit      = in_acc;
            emit_x    = i_x;
            emit_y    = i_y;
            emit_last = i_last;
        end else begin
            unique case (r_fill)
                FILL_EMPTY: begin
                    o_in_ready = 1'b1;
                    if (in_acc) begin
                        n_cur_x = i_x;
                        n_cur_y = i_y;
                        n_fill  = i_last ? FILL_LAST : FILL_FIRST;
                    end
                end
                FILL_FIRST, FILL_INNER: begin
                    if (in_acc) begin
                        emit = 1'b1;
                        if (r_fill == FILL_INNER) begin
                            emit_x = smooth3(r_prev_x, r_cur_x, i_x);
                            emit_y = smooth3(r_prev_y, r_cur_y, i_y);
                        end
                        n_prev_x = r_cur_x;
                        n_prev_y = r_cur_y;
                        n_cur_x  = i_x;
                        n_cur_y  = i_y;
                        n_fill   = i_last ? FILL_LAST : FILL_INNER;
                    end
                end
                FILL_LAST: begin
                    // final vertex leaves on its own, next polygon may enter meanwhile
                    if (load_ok) begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        n_fill    = FILL_EMPTY;
                    end
                    if (in_acc) begin
                        n_cur_x = i_x;
                        n_cur_y = i_y;
                        n_fill  = i_last ? FILL_LAST : FILL_FIRST;
                    end
                end
                default: begin
                    n_fill = FILL_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= FILL_EMPTY;
            r_out_valid <= 1'b0;
        end else if (i_clear) begin
            r_fill      <= FILL_EMPTY;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev_x <= n_prev_x;
        r_prev_y <= n_prev_y;
        r_cur_x  <= n_cur_x;
        r_cur_y  <= n_cur_y;
        if (emit) begin
            r_out_x    <= emit_x;
            r_out_y    <= emit_y;
            r_out_last <= emit_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_x         = r_out_x;
    assign o_y         = r_out_y;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

/* bench/polygon_binomial_smoother_tb.sv */
// self-checking bench for the polygon binomial smoother with a small scoreboard class

typedef logic signed [pbs_pkg::COORD_BITS_DEF-1:0] coord_t;

typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
} vertex_t;

typedef enum logic [1:0] {
    CELL_EMPTY,
    CELL_FIRST,
    CELL_INTERIOR
} cell_fill_e;

class smoothing_scoreboard;
    int unsigned mismatches;
    int unsigned active_passes;
    vertex_t     prev_v [pbs_pkg::MAX_PASSES_DEF];
    vertex_t     cur_v  [pbs_pkg::MAX_PASSES_DEF];
    cell_fill_e  fill   [pbs_pkg::MAX_PASSES_DEF];
    vertex_t     smoothed_q [$];

    function new();
        mismatches = 0;
        load_passes(pbs_pkg::PASSES_RESET);
    endfunction

    // any passes write also flushes every cell
    function void load_passes(int unsigned value);
        active_passes = (value > pbs_pkg::MAX_PASSES_DEF) ? pbs_pkg::MAX_PASSES_DEF : value;
        for (int s = 0; s < pbs_pkg::MAX_PASSES_DEF; s++) begin
            prev_v[s] = '0;
            cur_v[s]  = '0;
            fill[s]   = CELL_EMPTY;
        end
    endfunction

    function coord_t smooth_tap(coord_t a, coord_t b, coord_t c);
        int total;
        total = int'(a) + 2 * int'(b) + int'(c);
        return coord_t'(total / 4);
    endfunction

    function void note_vertex(vertex_t v);
        vertex_t stream [$];
        vertex_t released [$];
        vertex_t held;
        stream.push_back(v);
        for (int s = 0; s < active_passes; s++) begin
            released.delete();
            foreach (stream[i]) begin
                if (fill[s] == CELL_EMPTY) begin
                    if (stream[i].last) begin
                        released.push_back(stream[i]);
                    end else begin
                        cur_v[s] = stream[i];
                        fill[s]  = CELL_FIRST;
                    end
                end else begin
                    held = cur_v[s];
                    // first vertex of the polygon leaves unchanged
                    if (fill[s] == CELL_INTERIOR) begin
                        held.x = smooth_tap(prev_v[s].x, cur_v[s].x, stream[i].x);
                        held.y = smooth_tap(prev_v[s].y, cur_v[s].y, stream[i].y);
                    end
                    held.last = 1'b0;
                    released.push_back(held);
                    if (stream[i].last) begin
                        released.push_back(stream[i]);
                        fill[s] = CELL_EMPTY;
                    end else begin
                        prev_v[s] = cur_v[s];
                        cur_v[s]  = stream[i];
                        fill[s]   = CELL_INTERIOR;
                    end
                end
            end
            stream = released;
        end
        foreach (stream[i]) smoothed_q.push_back(stream[i]);
    endfunction

    function int pending();
        return smoothed_q.size();
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task check_vertex(vertex_t got);
        vertex_t want;
        if (smoothed_q.size() == 0) begin
            report($sformatf("unexpected vertex x=%0d y=%0d end=%0b",
                             got.x, got.y, got.last));
            return;
        end
        want = smoothed_q.pop_front();
        if (got.x !== want.x)
            report($sformatf("smooth_x got %0d want %0d", got.x, want.x));
        if (got.y !== want.y)
            report($sformatf("smooth_y got %0d want %0d", got.y, want.y));
        if (got.last !== want.last)
            report($sformatf("end_of_polygon got %0b want %0b", got.last, want.last));
    endtask
endclass

module polygon_binomial_smoother_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES  = 2 * pbs_pkg::MAX_PASSES_DEF + 8;
    localparam int RANDOM_ITEMS  = 450;
    localparam int MAX_COORD     = 8191;
    localparam int MIN_COORD     = -8192;
    localparam int PASSES_W      = pbs_pkg::PASSES_BITS;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [pbs_pkg::PASSES_BITS-1:0] i_cfg_passes = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    coord_t                          i_x_coord = '0;
    coord_t                          i_y_coord = '0;
    logic                            i_last_vertex = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    coord_t                          o_smooth_x;
    coord_t                          o_smooth_y;
    logic                            o_end_of_polygon;

    smoothing_scoreboard sb = new();
    bit                  quiet_phase = 1'b0;
    int                  items_sent = 0;

    polygon_binomial_smoother u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_passes     (i_cfg_passes),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_x_coord        (i_x_coord),
        .i_y_coord        (i_y_coord),
        .i_last_vertex    (i_last_vertex),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_smooth_x       (o_smooth_x),
        .o_smooth_y       (o_smooth_y),
        .o_end_of_polygon (o_end_of_polygon)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("[polygon_binomial_smoother] ERROR");
        $finish;
    end

    // handshakes are sampled mid-cycle, when every input and ready is settled
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.load_passes(32'(i_cfg_passes));
            if (i_in_valid && o_in_ready)
                sb.note_vertex(vertex_t'{i_x_coord, i_y_coord, i_last_vertex});
            if (o_out_valid && i_out_ready)
                sb.check_vertex(vertex_t'{o_smooth_x, o_smooth_y, o_end_of_polygon});
        end
    end

    function automatic int unsigned draw_gap();
        if (quiet_phase || $urandom_range(0, 4) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic coord_t draw_coord();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: return coord_t'(MAX_COORD);
                    1: return coord_t'(MIN_COORD);
                    2: return coord_t'(-1);
                    default: return '0;
                endcase
            end
            1: return coord_t'(int'($urandom_range(0, 16)) - 8);
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic send_vertex(vertex_t v);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_x_coord     <= v.x;
        i_y_coord     <= v.y;
        i_last_vertex <= v.last;
        do @(negedge i_clk); while (!(i_in_valid && o_in_ready));
        @(posedge i_clk);
        items_sent++;
    endtask

    // with any pass active, part of an open polygon stays held in the cells until the next passes write
    task automatic send_polygon(int unsigned count, bit closed);
        for (int unsigned i = 0; i < count; i++)
            send_vertex(vertex_t'{draw_coord(), draw_coord(), closed && (i == count - 1)});
    endtask

    task automatic write_passes(logic [pbs_pkg::PASSES_BITS-1:0] value);
        i_cfg_valid  <= 1'b1;
        i_cfg_passes <= value;
        do @(negedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_gap();
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(negedge i_clk); while (!(o_out_valid && i_out_ready));
            @(posedge i_clk);
        end
    end

    initial begin
        int unsigned phase;
        int unsigned polygons;
        logic [pbs_pkg::PASSES_BITS-1:0] setting;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset passes: single vertex, pair, triangle, and truncation toward zero
        send_vertex(vertex_t'{coord_t'(MAX_COORD), coord_t'(MIN_COORD), 1'b1});
        send_vertex(vertex_t'{coord_t'(MIN_COORD), coord_t'(MAX_COORD), 1'b0});
        send_vertex(vertex_t'{coord_t'(MAX_COORD), coord_t'(MIN_COORD), 1'b1});
        send_vertex(vertex_t'{coord_t'(MAX_COORD), coord_t'(MAX_COORD), 1'b0});
        send_vertex(vertex_t'{coord_t'(MIN_COORD), coord_t'(MIN_COORD), 1'b0});
        send_vertex(vertex_t'{coord_t'(MAX_COORD), coord_t'(MAX_COORD), 1'b1});
        send_vertex(vertex_t'{coord_t'(0), coord_t'(0), 1'b0});
        send_vertex(vertex_t'{coord_t'(-1), coord_t'(1), 1'b0});
        send_vertex(vertex_t'{coord_t'(-3), coord_t'(3), 1'b0});
        send_vertex(vertex_t'{coord_t'(0), coord_t'(0), 1'b1});
        wait_idle();

        // above the cell count, clamps to all cells
        write_passes(4'd15);
        for (int i = 0; i < 6; i++)
            send_vertex(vertex_t'{(i % 2) ? coord_t'(MIN_COORD) : coord_t'(MAX_COORD),
                                  (i % 2) ? coord_t'(MAX_COORD) : coord_t'(MIN_COORD),
                                  i == 5});
        wait_idle();

        // partial polygon is dropped by the next write
        write_passes(4'd3);
        send_vertex(vertex_t'{coord_t'(100), coord_t'(-100), 1'b0});
        send_vertex(vertex_t'{coord_t'(-200), coord_t'(200), 1'b0});
        wait_idle();
        write_passes(4'd0);
        send_vertex(vertex_t'{coord_t'(5), coord_t'(-5), 1'b0});
        send_vertex(vertex_t'{coord_t'(-7), coord_t'(7), 1'b0});
        send_vertex(vertex_t'{coord_t'(1), coord_t'(1), 1'b1});
        wait_idle();

        write_passes(PASSES_W'(pbs_pkg::MAX_PASSES_DEF));
        send_vertex(vertex_t'{coord_t'(MIN_COORD), coord_t'(MAX_COORD), 1'b0});
        send_vertex(vertex_t'{coord_t'(MIN_COORD), coord_t'(MAX_COORD), 1'b0});
        send_vertex(vertex_t'{coord_t'(MAX_COORD), coord_t'(MIN_COORD), 1'b1});

        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            wait_idle();
            case (phase)
                0: setting = '0;
                1: setting = PASSES_W'(pbs_pkg::MAX_PASSES_DEF);
                2: setting = '1;
                default: setting = PASSES_W'($urandom_range(0, 15));
            endcase
            write_passes(setting);
            quiet_phase = ($urandom_range(0, 3) == 0);
            polygons = $urandom_range(2, 8);
            repeat (polygons) begin
                if ($urandom_range(0, 9) == 0)
                    send_polygon($urandom_range(13, 40), 1'b1);
                else
                    send_polygon($urandom_range(1, 12), 1'b1);
            end
            if ($urandom_range(0, 4) == 0)
                send_polygon($urandom_range(1, 4), 1'b0);
            phase++;
        end

        wait_idle();
        if (sb.mismatches == 0)
            $display("[polygon_binomial_smoother] OK");
        else
            $display("[polygon_binomial_smoother] ERROR");
        $finish;
    end
endmodule
